// File: rtl/sorted_task_priority_queue_assert.svh
// Assertion macros shared by the checker of the sorted task priority queue.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef SORTED_TASK_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_TASK_PRIORITY_QUEUE_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define STPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that also holds while reset is held.
`define STPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/stpq_pkg.sv
// Package of the sorted task priority queue: sizes, entry and control types.
// Used by every module of the block; depends on nothing.
package stpq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int PRIORITY_WIDTH = 8;
  localparam int TAG_WIDTH      = 16;
  localparam int OCC_WIDTH      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  // One slot of the queue.
  typedef struct packed {
    logic                      vld;
    logic [PRIORITY_WIDTH-1:0] pri;
    logic [TAG_WIDTH-1:0]      tag;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ins;
  } cell_ctl_t;

endpackage

// File: rtl/stpq_cell.sv
// One compare-and-shift cell of the sorted queue row.
// Depends on stpq_pkg for the entry and control types.
module stpq_cell import stpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  entry_t    left_i,
  input  logic      left_gt_i,
  input  entry_t    right_i,
  output entry_t    entry_o,
  output logic      gt_o
);

  logic                      vld_q;
  logic [PRIORITY_WIDTH-1:0] pri_q;
  logic [TAG_WIDTH-1:0]      tag_q;
  entry_t                    entry_q;
  entry_t                    entry_d;

  assign entry_q = {vld_q, pri_q, tag_q};

  // An empty slot or one holding a strictly larger priority yields to the new entry.
  assign gt_o = !entry_q.vld || (entry_q.pri > ctl_i.ins.pri);

  // A push shifts right from the insertion point; a pop shifts everything left.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.push) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o) begin
        entry_d = ctl_i.ins;
      end
    end else if (ctl_i.pop) begin
      entry_d = right_i;
    end
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= entry_d.vld;
    end
  end

  // Priority and tag are payload only.
  always_ff @(posedge clk_i) begin
    pri_q <= entry_d.pri;
    tag_q <= entry_d.tag;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/sorted_task_priority_queue.sv
// Top level of the sorted task priority queue: a row of stpq_cell slots and a result register.
// Depends on stpq_pkg and stpq_cell.
//
//  Channel | Handshake                     | Payload
//  --------+-------------------------------+---------------------------------------------
//  in      | in_valid_i / in_stall_o       | kind_i, priority_req_i, task_tag_i
//  out     | out_valid_o / out_stall_i     | popped_valid_o, popped_priority_o,
//          |                               | popped_tag_o, overflow_o, occupancy_o
//
// For each input beat, every cell compares against the new priority and shifts in the
// same cycle, and the result beat appears in the cycle after acceptance.
// One beat can be accepted in every cycle as long as the output side takes results.
// Reset empties the queue at once; no clearing pass is needed.
// The input is stalled only while a result is held and the output side stalls.
module sorted_task_priority_queue import stpq_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [PRIORITY_WIDTH-1:0] priority_req_i,
  input  logic [TAG_WIDTH-1:0]      task_tag_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      popped_valid_o,
  output logic [PRIORITY_WIDTH-1:0] popped_priority_o,
  output logic [TAG_WIDTH-1:0]      popped_tag_o,
  output logic                      overflow_o,
  output logic [OCC_WIDTH-1:0]      occupancy_o
);

  entry_t                   cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_gt;
  cell_ctl_t                ctl;
  kind_e                    kind;
  logic                     accept;
  logic                     full;
  logic                     head_vld;
  logic                     out_valid_q;
  logic                     popped_valid_q, popped_valid_d;
  logic [PRIORITY_WIDTH-1:0] popped_priority_q, popped_priority_d;
  logic [TAG_WIDTH-1:0]     popped_tag_q, popped_tag_d;
  logic                     overflow_q, overflow_d;
  logic [OCC_WIDTH-1:0]     count_q, count_d;

  // Input handshake: a new beat waits only while a result beat is blocked.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign kind       = kind_e'(kind_i);

  assign full     = cell_entry[QUEUE_DEPTH-1].vld;
  assign head_vld = cell_entry[0].vld;

  // Operation broadcast to the cell row.
  always_comb begin
    ctl.push    = accept && (kind == KIND_PUSH) && !full;
    ctl.pop     = accept && (kind == KIND_POP) && head_vld;
    ctl.ins.vld = 1'b1;
    ctl.ins.pri = priority_req_i;
    ctl.ins.tag = task_tag_i;
  end

  // Row of cells; the ends see an empty neighbor.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_gt;
    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end
    stpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .left_i    (left_entry),
      .left_gt_i (left_gt),
      .right_i   (right_entry),
      .entry_o   (cell_entry[i]),
      .gt_o      (cell_gt[i])
    );
  end

  // Result of the accepted beat and the new fill level.
  always_comb begin
    popped_valid_d    = ctl.pop;
    popped_priority_d = ctl.pop ? cell_entry[0].pri : '0;
    popped_tag_d      = ctl.pop ? cell_entry[0].tag : '0;
    overflow_d        = accept && (kind == KIND_PUSH) && full;
    count_d           = count_q;
    if (ctl.push) begin
      count_d = count_q + OCC_WIDTH'(1);
    end else if (ctl.pop) begin
      count_d = count_q - OCC_WIDTH'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register, loaded on each accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_valid_q    <= popped_valid_d;
      popped_priority_q <= popped_priority_d;
      popped_tag_q      <= popped_tag_d;
      overflow_q        <= overflow_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign popped_valid_o    = popped_valid_q;
  assign popped_priority_o = popped_priority_q;
  assign popped_tag_o      = popped_tag_q;
  assign overflow_o        = overflow_q;
  assign occupancy_o       = count_q;

endmodule

// File: rtl/stpq_checker.sv
// Port-level checker for the sorted task priority queue, bound to the top level.
// Depends on stpq_pkg and sorted_task_priority_queue_assert.svh.
`include "sorted_task_priority_queue_assert.svh"

module stpq_checker import stpq_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      kind_i,
  input logic [PRIORITY_WIDTH-1:0] priority_req_i,
  input logic [TAG_WIDTH-1:0]      task_tag_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      popped_valid_o,
  input logic [PRIORITY_WIDTH-1:0] popped_priority_o,
  input logic [TAG_WIDTH-1:0]      popped_tag_o,
  input logic                      overflow_o,
  input logic [OCC_WIDTH-1:0]      occupancy_o
);

  logic push_beat;
  logic pop_beat;
  logic occ_full;
  logic no_data;

  assign push_beat = in_valid_i && !in_stall_o && (kind_i == KIND_PUSH);
  assign pop_beat  = in_valid_i && !in_stall_o && (kind_i == KIND_POP);
  assign occ_full  = (occupancy_o == OCC_WIDTH'(QUEUE_DEPTH));
  assign no_data   = (popped_tag_o == '0) && (popped_priority_o == '0);

  // A held result beat stays until it is taken.
  `STPQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped")

  // Every accepted beat yields a result beat in the next cycle.
  `STPQ_ASSERT(a_one_result, (push_beat || pop_beat) |=> out_valid_o, "beat gave no result")

  // A dropped push is reported only when the queue is at full depth.
  `STPQ_ASSERT(a_ovf_full, out_valid_o && overflow_o |-> occ_full, "overflow below full depth")

  // No result beat is offered in the cycle after reset was seen low.
  `STPQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result beat during reset")

  // A result that removed nothing carries zero priority and tag.
  `STPQ_ASSERT(a_empty_pop, out_valid_o && !popped_valid_o |-> no_data, "empty result has data")

  logic unused_payload;
  assign unused_payload = ^{priority_req_i, task_tag_i};

endmodule

bind sorted_task_priority_queue stpq_checker u_stpq_checker (.*);
